[rtl/core/sdf_pkg.sv]
package sdf_pkg;

  localparam int MAG_W         = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int BCD_W         = 4 * NUM_DIGITS;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = MAG_W / BITS_PER_STEP;
  localparam int ITER_W        = $clog2(CONV_STEPS);
  localparam int LEN_W         = 6;
  localparam int DIG_W         = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NONE  = 8'h00;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_CONV  = 4'd1;
  localparam step_t S_NDIG  = 4'd2;
  localparam step_t S_ZERO  = 4'd3;
  localparam step_t S_PAD   = 4'd4;
  localparam step_t S_LPAD  = 4'd5;
  localparam step_t S_SIGN  = 4'd6;
  localparam step_t S_ZEROS = 4'd7;
  localparam step_t S_DIGS  = 4'd8;
  localparam step_t S_RPAD  = 4'd9;
  localparam step_t S_EMPTY = 4'd10;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_CONV,
    OP_NDIG,
    OP_ZERO,
    OP_PAD,
    OP_EMIT,
    OP_EMPTY
  } op_t;

  typedef enum logic [2:0] {
    RUN_NONE,
    RUN_LPAD,
    RUN_SIGN,
    RUN_ZERO,
    RUN_DIG,
    RUN_RPAD
  } run_t;

  typedef struct packed {
    op_t   op;
    run_t  run;
    step_t jump;
    step_t next;
  } ctrl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } conv_ctrl_t;

  // microcode ROM
  function automatic ctrl_t micro_rom(input step_t step);
    ctrl_t w;
    unique case (step)
      S_IDLE:  w = '{op: OP_WAIT,  run: RUN_NONE, jump: S_IDLE,  next: S_CONV};
      S_CONV:  w = '{op: OP_CONV,  run: RUN_NONE, jump: S_IDLE,  next: S_NDIG};
      S_NDIG:  w = '{op: OP_NDIG,  run: RUN_NONE, jump: S_IDLE,  next: S_ZERO};
      S_ZERO:  w = '{op: OP_ZERO,  run: RUN_NONE, jump: S_IDLE,  next: S_PAD};
      S_PAD:   w = '{op: OP_PAD,   run: RUN_NONE, jump: S_EMPTY, next: S_LPAD};
      S_LPAD:  w = '{op: OP_EMIT,  run: RUN_LPAD, jump: S_IDLE,  next: S_SIGN};
      S_SIGN:  w = '{op: OP_EMIT,  run: RUN_SIGN, jump: S_IDLE,  next: S_ZEROS};
      S_ZEROS: w = '{op: OP_EMIT,  run: RUN_ZERO, jump: S_IDLE,  next: S_DIGS};
      S_DIGS:  w = '{op: OP_EMIT,  run: RUN_DIG,  jump: S_IDLE,  next: S_RPAD};
      S_RPAD:  w = '{op: OP_EMIT,  run: RUN_RPAD, jump: S_IDLE,  next: S_IDLE};
      S_EMPTY: w = '{op: OP_EMPTY, run: RUN_NONE, jump: S_IDLE,  next: S_IDLE};
      default: w = '{op: OP_WAIT,  run: RUN_NONE, jump: S_IDLE,  next: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/signed_decimal_field_formatter.sv]
// printf "%d" formatter. Pulse start while busy is low to hand over one
// value with its field width, precision (-1 for none), left-justify and
// zero-pad flags. The text comes out one ASCII character at a time on
// out_char, each marked by a one-cycle valid strobe that cannot be held
// off; last marks the final character, which comes with the total length.
// A field with no characters gives one result with is_empty set.
// Sequence: a 10-digit shift-and-add-3 conversion at 4 bits per cycle,
// three steps that size the field, then five emit steps (left pad, sign,
// zeros, digits, right pad), each held until its run is emitted; an empty
// field takes one empty step in place of the emit steps. The microcode
// sequencer then returns to idle, where the next transfer is taken; busy
// stays high until then, so a new value waits until the last is through.
module signed_decimal_field_formatter #(
  parameter int MAX_FIELD = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value,
  input  logic [5:0]         field_width,
  input  logic signed [6:0]  precision,
  input  logic               left_justify,
  input  logic               zero_pad,
  output logic               valid,
  output logic [7:0]         out_char,
  output logic               is_empty,
  output logic               last,
  output logic [5:0]         total_length
);
  import sdf_pkg::*;

  localparam logic [LEN_W:0]   MAX_L7 = (LEN_W + 1)'(MAX_FIELD);
  localparam logic [LEN_W-1:0] MAX_L  = LEN_W'(MAX_FIELD);

  step_t             pc;
  step_t             pc_next;
  ctrl_t             cw;
  logic [ITER_W-1:0] iter;
  conv_ctrl_t        conv;
  logic [BCD_W-1:0]  bcd;
  logic [MAG_W-1:0]  mag_c;
  logic              accept;

  logic              neg;
  logic              has_prec;
  logic [LEN_W-1:0]  prec_v;
  logic              left;
  logic              zflag;
  logic [LEN_W-1:0]  width_r;
  logic [DIG_W-1:0]  nd;
  logic [DIG_W-1:0]  dig_cnt;
  logic [LEN_W-1:0]  zero_cnt;
  logic [LEN_W-1:0]  pad_cnt;
  logic              sign_left;
  logic [LEN_W-1:0]  total;
  logic [LEN_W-1:0]  pos;

  logic [3:0]        digit [NUM_DIGITS];
  logic [DIG_W-1:0]  top_c;
  logic [DIG_W-1:0]  nd_c;
  logic [LEN_W-1:0]  zeros_c;
  logic [LEN_W:0]    body7_c;
  logic [LEN_W-1:0]  body_c;
  logic [LEN_W-1:0]  pad_c;
  logic [LEN_W-1:0]  total_c;
  logic              merge_c;
  logic [LEN_W-1:0]  remaining;
  logic              emit;
  logic [7:0]        char_c;
  logic [3:0]        dig_sel;
  logic [DIG_W-1:0]  dig_idx;
  logic              last_c;

  assign cw     = micro_rom(pc);
  assign busy   = (pc != S_IDLE);
  assign accept = start && !busy;
  assign mag_c  = value[31] ? (~value + 32'sd1) : value;

  assign conv.load  = accept;
  assign conv.shift = (cw.op == OP_CONV);

  sdf_bcd_conv u_conv (
    .clk  (clk),
    .ctrl (conv),
    .mag  (mag_c),
    .bcd  (bcd)
  );

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digit[i] = bcd[i*4 +: 4];
    end
  end

  // digit count
  always_comb begin
    top_c = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digit[i] != 4'd0) begin
        top_c = DIG_W'(i + 1);
      end
    end
    if (has_prec && prec_v == '0 && top_c == '0) begin
      nd_c = '0;
    end else if (top_c == '0) begin
      nd_c = DIG_W'(1);
    end else begin
      nd_c = top_c;
    end
  end

  // precision zeros, capped so the body fits the field bound
  always_comb begin
    if (has_prec && prec_v > LEN_W'(nd)) begin
      zeros_c = prec_v - LEN_W'(nd);
    end else begin
      zeros_c = '0;
    end
    body7_c = (LEN_W + 1)'(neg) + {1'b0, zeros_c} + (LEN_W + 1)'(nd);
    if (body7_c > MAX_L7) begin
      zeros_c = MAX_L - LEN_W'(neg) - LEN_W'(nd);
    end
  end

  // padding and total
  always_comb begin
    body_c  = LEN_W'(neg) + zero_cnt + LEN_W'(nd);
    pad_c   = (width_r > body_c) ? (width_r - body_c) : '0;
    merge_c = zflag && !left && !has_prec;
    total_c = body_c + pad_c;
  end

  // emit datapath
  always_comb begin
    case (cw.run)
      RUN_LPAD: remaining = left ? '0 : pad_cnt;
      RUN_SIGN: remaining = LEN_W'(sign_left);
      RUN_ZERO: remaining = zero_cnt;
      RUN_DIG:  remaining = LEN_W'(dig_cnt);
      RUN_RPAD: remaining = left ? pad_cnt : '0;
      default:  remaining = '0;
    endcase
    emit    = (cw.op == OP_EMIT) && (remaining != '0);
    dig_idx = dig_cnt - DIG_W'(1);
    dig_sel = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (dig_idx == DIG_W'(i)) begin
        dig_sel = digit[i];
      end
    end
    case (cw.run)
      RUN_SIGN: char_c = CH_MINUS;
      RUN_ZERO: char_c = CH_ZERO;
      RUN_DIG:  char_c = CH_ZERO + {4'd0, dig_sel};
      default:  char_c = CH_SPACE;
    endcase
    last_c = (pos + LEN_W'(1)) == total;
  end

  // sequencer
  always_comb begin
    pc_next = cw.next;
    unique case (cw.op)
      OP_WAIT:  pc_next = start ? cw.next : pc;
      OP_CONV:  pc_next = (iter == ITER_W'(CONV_STEPS - 1)) ? cw.next : pc;
      OP_NDIG:  pc_next = cw.next;
      OP_ZERO:  pc_next = cw.next;
      OP_PAD:   pc_next = (total_c == '0) ? cw.jump : cw.next;
      OP_EMIT:  pc_next = (remaining > LEN_W'(1)) ? pc : cw.next;
      OP_EMPTY: pc_next = cw.next;
      default:  pc_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= S_IDLE;
      iter  <= '0;
      valid <= 1'b0;
    end else begin
      pc    <= pc_next;
      valid <= emit || (cw.op == OP_EMPTY);
      if (accept) begin
        iter <= '0;
      end else if (cw.op == OP_CONV) begin
        iter <= iter + ITER_W'(1);
      end
    end

    if (accept) begin
      neg      <= value[31];
      has_prec <= !precision[6];
      prec_v   <= precision[LEN_W-1:0];
      left     <= left_justify;
      zflag    <= zero_pad;
      width_r  <= (field_width > MAX_L) ? MAX_L : field_width;
      pos      <= '0;
    end

    unique case (cw.op)
      OP_NDIG: begin
        nd      <= nd_c;
        dig_cnt <= nd_c;
      end
      OP_ZERO: begin
        zero_cnt <= zeros_c;
      end
      OP_PAD: begin
        sign_left <= neg;
        total     <= total_c;
        if (merge_c) begin
          zero_cnt <= zero_cnt + pad_c;
          pad_cnt  <= '0;
        end else begin
          pad_cnt  <= pad_c;
        end
      end
      OP_EMIT: begin
        if (emit) begin
          case (cw.run)
            RUN_SIGN: sign_left <= 1'b0;
            RUN_ZERO: zero_cnt  <= zero_cnt - LEN_W'(1);
            RUN_DIG:  dig_cnt   <= dig_cnt - DIG_W'(1);
            default:  pad_cnt   <= pad_cnt - LEN_W'(1);
          endcase
          pos          <= pos + LEN_W'(1);
          out_char     <= char_c;
          is_empty     <= 1'b0;
          last         <= last_c;
          total_length <= last_c ? total : '0;
        end
      end
      OP_EMPTY: begin
        out_char     <= CH_NONE;
        is_empty     <= 1'b1;
        last         <= 1'b1;
        total_length <= '0;
      end
      default: begin
      end
    endcase
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    valid && is_empty |-> last)
    else $error("empty result without last");

  a_len_only_on_last: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> total_length == '0)
    else $error("length on a non-final transfer");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    valid && last && !is_empty |-> total_length != '0)
    else $error("final character with zero length");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && pc == S_CONV)
    else $error("accepted item did not start conversion");

  a_emit_in_flight: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("result strobe without work in progress");

endmodule

[rtl/core/sdf_bcd_conv.sv]
module sdf_bcd_conv (
  input  logic                                clk,
  input  sdf_pkg::conv_ctrl_t                 ctrl,
  input  logic [sdf_pkg::MAG_W-1:0]           mag,
  output logic [sdf_pkg::BCD_W-1:0]           bcd
);
  import sdf_pkg::*;

  logic [MAG_W-1:0] bin;
  logic [MAG_W-1:0] bin_next;
  logic [BCD_W-1:0] bcd_next;

  // shift-and-add-3, several bits per cycle
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [MAG_W-1:0] s;
    b = bcd;
    s = bin;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], s[MAG_W-1]};
      s = {s[MAG_W-2:0], 1'b0};
    end
    bcd_next = b;
    bin_next = s;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= mag;
      bcd <= '0;
    end else if (ctrl.shift) begin
      bin <= bin_next;
      bcd <= bcd_next;
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int MAX_FIELD = 63;
  localparam logic [7:0] CH_SPACE = sdf_pkg::CH_SPACE;
  localparam logic [7:0] CH_MINUS = sdf_pkg::CH_MINUS;
  localparam logic [7:0] CH_ZERO  = sdf_pkg::CH_ZERO;
  localparam logic [7:0] CH_NONE  = sdf_pkg::CH_NONE;
  localparam logic signed [6:0] NO_PREC = -7'sd1;

  typedef struct {
    logic [7:0] ch;
    logic       empty;
    logic       fin;
    logic [5:0] len;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] value = '0;
  logic [5:0]         field_width = '0;
  logic signed [6:0]  precision = '0;
  logic               left_justify = 1'b0;
  logic               zero_pad = 1'b0;
  logic               valid;
  logic [7:0]         out_char;
  logic               is_empty;
  logic               last;
  logic [5:0]         total_length;

  text_char_t pending_chars[$];
  text_char_t want;
  int  error_count = 0;
  int  values_sent = 0;
  int  chars_seen = 0;
  int  empties_seen = 0;
  bit  no_gaps = 1'b0;

  signed_decimal_field_formatter #(.MAX_FIELD(MAX_FIELD)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .field_width(field_width),
    .precision(precision),
    .left_justify(left_justify),
    .zero_pad(zero_pad),
    .valid(valid),
    .out_char(out_char),
    .is_empty(is_empty),
    .last(last),
    .total_length(total_length)
  );

  always #6 clk = ~clk;

  // builds the expected text of one field and queues it
  function automatic void format_decimal(logic signed [31:0] v, logic [5:0] fw,
                                         logic signed [6:0] pr, logic lj, logic zp);
    logic [31:0] mag;
    logic [7:0]  digs[$];
    logic [7:0]  text[$];
    text_char_t  r;
    int prec, nd, sgn, zeros, width, body, pad, total;
    bit has_prec, neg;
    prec = pr;
    has_prec = prec >= 0;
    neg = v[31];
    mag = neg ? 32'd0 - v : v;
    if (!(has_prec && prec == 0 && mag == 0)) begin
      do begin
        digs.push_front(CH_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
    end
    nd = digs.size();
    sgn = neg ? 1 : 0;
    zeros = 0;
    if (has_prec && prec > nd) zeros = prec - nd;
    if (sgn + zeros + nd > MAX_FIELD) zeros = MAX_FIELD - sgn - nd;
    width = fw > MAX_FIELD ? MAX_FIELD : fw;
    body = sgn + zeros + nd;
    pad = width > body ? width - body : 0;
    if (zp && !lj && !has_prec) begin
      zeros += pad;
      pad = 0;
    end
    total = sgn + zeros + nd + pad;
    if (total == 0) begin
      r = '{ch: CH_NONE, empty: 1'b1, fin: 1'b1, len: 6'd0};
      pending_chars.push_back(r);
      return;
    end
    if (!lj) repeat (pad) text.push_back(CH_SPACE);
    if (neg) text.push_back(CH_MINUS);
    repeat (zeros) text.push_back(CH_ZERO);
    foreach (digs[i]) text.push_back(digs[i]);
    if (lj) repeat (pad) text.push_back(CH_SPACE);
    foreach (text[i]) begin
      r.ch = text[i];
      r.empty = 1'b0;
      r.fin = (i == total - 1);
      r.len = r.fin ? 6'(total) : 6'd0;
      pending_chars.push_back(r);
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_value(logic signed [31:0] v, logic [5:0] fw, logic signed [6:0] pr,
                            logic lj, logic zp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    field_width <= fw;
    precision <= pr;
    left_justify <= lj;
    zero_pad <= zp;
    do @(posedge clk); while (busy);
    format_decimal(v, fw, pr, lj, zp);
    values_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (MAX_FIELD + 24) @(posedge clk);
  endtask

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      error_count++;
      if (error_count <= 40)
        $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && valid) begin
      chars_seen++;
      if (is_empty) empties_seen++;
      if (pending_chars.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transfer out_char %0d last %0d", $time, out_char, last);
      end else begin
        want = pending_chars.pop_front();
        check_field("out_char", want.ch, out_char);
        check_field("is_empty", want.empty, is_empty);
        check_field("last", want.fin, last);
        check_field("total_length", want.len, total_length);
      end
    end
  end

  task automatic test_corner_values();
    send_value(32'sd0, 6'd0, NO_PREC, 1'b0, 1'b0);
    send_value(32'sd1, 6'd0, NO_PREC, 1'b0, 1'b0);
    send_value(-32'sd1, 6'd0, NO_PREC, 1'b0, 1'b0);
    send_value(32'sh7fff_ffff, 6'd0, NO_PREC, 1'b0, 1'b0);
    send_value(32'sh8000_0000, 6'd0, NO_PREC, 1'b0, 1'b0);
    send_value(32'sh8000_0000, 6'd63, NO_PREC, 1'b1, 1'b0);
    send_value(32'sh8000_0000, 6'd20, NO_PREC, 1'b0, 1'b1);
    send_value(32'sh7fff_ffff, 6'd11, NO_PREC, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_padding_modes();
    send_value(32'sd42, 6'd8, NO_PREC, 1'b0, 1'b0);
    send_value(32'sd42, 6'd8, NO_PREC, 1'b1, 1'b0);
    send_value(-32'sd42, 6'd8, NO_PREC, 1'b0, 1'b1);
    send_value(-32'sd42, 6'd8, NO_PREC, 1'b1, 1'b1);
    send_value(-32'sd42, 6'd8, 7'sd3, 1'b0, 1'b1);
    send_value(32'sd7, 6'd63, NO_PREC, 1'b0, 1'b0);
    send_value(-32'sd7, 6'd63, NO_PREC, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_precision();
    send_value(32'sd0, 6'd0, 7'sd0, 1'b0, 1'b0);
    send_value(32'sd0, 6'd4, 7'sd0, 1'b0, 1'b0);
    send_value(32'sd0, 6'd4, 7'sd0, 1'b1, 1'b1);
    send_value(32'sd5, 6'd0, 7'sd62, 1'b0, 1'b0);
    send_value(-32'sd5, 6'd63, 7'sd62, 1'b1, 1'b0);
    send_value(32'sh8000_0000, 6'd0, 7'sd62, 1'b0, 1'b1);
    send_value(32'sd123, 6'd8, -7'sd2, 1'b0, 1'b1);
    send_value(32'sd123, 6'd6, -7'sd64, 1'b0, 1'b0);
    send_value(32'sd0, 6'd0, NO_PREC, 1'b0, 1'b1);
    wait_drained();
  endtask

  function automatic logic signed [31:0] pick_value();
    int p;
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 99);
      1: return -$signed($urandom_range(0, 99));
      2: return $urandom_range(0, 3) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
      3: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        return p - $signed($urandom_range(0, 2)) + 1 - 1;
      end
      4: return -$signed($urandom_range(0, 100000));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [6:0] pick_precision();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return NO_PREC;
    if (roll < 7) return 7'($urandom_range(0, 12));
    if (roll < 8) return 7'($urandom_range(0, 62));
    if (roll < 9) return 7'($urandom);
    return 7'sd0;
  endfunction

  function automatic logic [5:0] pick_width();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return 6'($urandom_range(0, 4));
    if (roll < 8) return 6'($urandom_range(0, 16));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic test_random_mix();
    logic signed [31:0] v;
    for (int n = 0; n < 350; n++) begin
      no_gaps = (n % 70) >= 50;
      v = pick_value();
      if ($urandom_range(0, 15) == 0) v = 32'sd0;
      send_value(v, pick_width(), pick_precision(), 1'($urandom), 1'($urandom));
    end
    no_gaps = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_values();
    test_padding_modes();
    test_precision();
    test_random_mix();
    $display("%0d values formatted, %0d characters checked, %0d empty fields",
             values_sent, chars_seen, empties_seen);
    $display("covered extremes, padding and precision cases, then random fields");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/sdf_pkg.sv
rtl/core/sdf_bcd_conv.sv
rtl/core/signed_decimal_field_formatter.sv
sim/tb.sv
